>>> src/lba_pkg.sv
// Shared types, constants and codes of the linked block allocator.
package lba_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int NUM_FILES  = 128;
   localparam int BLK_W      = $clog2(NUM_BLOCKS);
   localparam int LINK_W     = BLK_W + 1;
   localparam int FILE_W     = 7;
   localparam int CNT_W      = 4;

   // End-of-chain mark: the value NUM_BLOCKS.
   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);

   localparam logic [CNT_W-1:0] MAX_BLOCKS_RESET = 4'd10;

   localparam logic REQ_ALLOC  = 1'b0;
   localparam logic REQ_FORMAT = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_LIMIT   = 2'd1;
   localparam logic [1:0] STATUS_NO_FREE = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [FILE_W-1:0] file_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [BLK_W-1:0] block_index;
   } rsp_word_type;

   typedef struct packed {
      logic [BLK_W-1:0] head;
      logic [CNT_W-1:0] count;
   } file_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

>>> src/linked_block_allocator_unit.sv
// Top level of the linked block allocator: control sequencer, file table and link RAM.
//
// Usage: a request word on req_word (req_valid/req_stall) either allocates one
// block for file_index or formats the whole pool. Each request gives exactly
// one response word on rsp_word (rsp_valid/rsp_stall) carrying a status and
// the allocated block number (zero unless the status is ok).
// csr_wr_en/csr_wr_data write the per-file block limit; write it only while
// the block is idle.
// Sequence: an allocation reads the file table entry, then walks the file's
// chain to its tail, where each link of the chain costs one read of the link
// RAM; no new request is taken until the result is in the output register.
// A refused allocation, an allocation to an empty file and a format skip the
// walk. The response word is registered when the sequencer leaves its
// finishing state.
// Reset (synchronous, active high) and format both empty every file and make
// the whole pool free again at once; no clearing pass is needed.
// A stalled response sits in the output register while the next request is
// still accepted and worked on; only the finished result waits for the slot.
module linked_block_allocator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lba_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lba_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data
);

   // Blocks are only ever handed out in index order and are returned only by
   // a format, so the free list is simply every block at or above free_ff.
   // Link entries below free_ff were all written since the last format, and
   // the link RAM therefore needs no reset at all.

   lba_pkg::state_type state_ff, state_in;

   logic [lba_pkg::CNT_W-1:0]  max_ff;
   logic [lba_pkg::LINK_W-1:0] free_ff, free_in;
   logic [lba_pkg::FILE_W-1:0] file_ff, file_in;
   logic [lba_pkg::BLK_W-1:0]  blk_ff, blk_in;
   logic [lba_pkg::BLK_W-1:0]  last_ff, last_in;
   lba_pkg::file_entry_type    entry_ff, entry_in;
   lba_pkg::rsp_word_type      res_ff, res_in;

   logic                       rsp_valid_ff;
   lba_pkg::rsp_word_type      rsp_word_ff;

   // File table: head and count per file, with one valid bit per file so
   // reset and format can empty every file at once.
   lba_pkg::file_entry_type    file_mem [lba_pkg::NUM_FILES];
   logic [lba_pkg::NUM_FILES-1:0] file_vld_ff;
   lba_pkg::file_entry_type    tab_rd_ff;
   logic                       tab_vld_ff;
   logic                       tab_re;
   logic                       tab_we;
   lba_pkg::file_entry_type    tab_wdata;
   lba_pkg::file_entry_type    cur_entry;

   logic                       link_we;
   logic [lba_pkg::BLK_W-1:0]  link_waddr;
   logic [lba_pkg::LINK_W-1:0] link_wdata;
   logic                       link_re;
   logic [lba_pkg::BLK_W-1:0]  link_raddr;
   logic [lba_pkg::LINK_W-1:0] link_rd;

   logic req_accept;
   logic is_format;
   logic format_now;
   logic limit_hit;
   logic pool_empty;
   logic link_end;
   logic rsp_load;

   assign req_stall  = (state_ff != lba_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_format  = (req_word.req_type == lba_pkg::REQ_FORMAT);
   assign format_now = req_accept && is_format;

   // A file whose valid bit is clear reads as empty.
   assign cur_entry  = tab_vld_ff ? tab_rd_ff : '0;
   assign limit_hit  = (cur_entry.count >= max_ff);
   assign pool_empty = (free_ff >= lba_pkg::LINK_END);
   assign link_end   = (link_rd >= lba_pkg::LINK_END);
   assign rsp_load   = (state_ff == lba_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   lba_link_ram #(
      .DEPTH (lba_pkg::NUM_BLOCKS),
      .WIDTH (lba_pkg::LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lba_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = is_format ? lba_pkg::ST_DONE : lba_pkg::ST_LOOKUP;
            end
         end
         lba_pkg::ST_LOOKUP: begin
            if (limit_hit || pool_empty || (cur_entry.count == '0)) begin
               state_in = lba_pkg::ST_DONE;
            end else begin
               state_in = lba_pkg::ST_WALK;
            end
         end
         lba_pkg::ST_WALK: begin
            if (link_end) begin
               state_in = lba_pkg::ST_DONE;
            end
         end
         lba_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = lba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lba_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory controls and datapath.
   always_comb begin
      file_in    = file_ff;
      blk_in     = blk_ff;
      last_in    = last_ff;
      entry_in   = entry_ff;
      free_in    = free_ff;
      res_in     = res_ff;
      tab_re     = 1'b0;
      tab_we     = 1'b0;
      tab_wdata  = entry_ff;
      link_we    = 1'b0;
      link_waddr = blk_ff;
      link_wdata = lba_pkg::LINK_END;
      link_re    = 1'b0;
      link_raddr = last_ff;
      case (state_ff)
         lba_pkg::ST_IDLE: begin
            if (req_accept) begin
               file_in = req_word.file_index;
               tab_re  = 1'b1;
               if (is_format) begin
                  free_in = '0;
                  res_in  = '{status: lba_pkg::STATUS_OK, block_index: '0};
               end
            end
         end
         lba_pkg::ST_LOOKUP: begin
            entry_in = cur_entry;
            blk_in   = free_ff[lba_pkg::BLK_W-1:0];
            last_in  = cur_entry.head;
            if (limit_hit) begin
               res_in = '{status: lba_pkg::STATUS_LIMIT, block_index: '0};
            end else if (pool_empty) begin
               res_in = '{status: lba_pkg::STATUS_NO_FREE, block_index: '0};
            end else begin
               // Pop the free block and terminate it.
               link_we    = 1'b1;
               link_waddr = free_ff[lba_pkg::BLK_W-1:0];
               link_wdata = lba_pkg::LINK_END;
               free_in    = free_ff + 1'b1;
               if (cur_entry.count == '0) begin
                  tab_we    = 1'b1;
                  tab_wdata = '{head: free_ff[lba_pkg::BLK_W-1:0], count: 4'd1};
                  res_in    = '{status: lba_pkg::STATUS_OK,
                                block_index: free_ff[lba_pkg::BLK_W-1:0]};
               end else begin
                  link_re    = 1'b1;
                  link_raddr = cur_entry.head;
               end
            end
         end
         lba_pkg::ST_WALK: begin
            if (link_end) begin
               link_we    = 1'b1;
               link_waddr = last_ff;
               link_wdata = {1'b0, blk_ff};
               tab_we     = 1'b1;
               tab_wdata  = '{head: entry_ff.head, count: entry_ff.count + 1'b1};
               res_in     = '{status: lba_pkg::STATUS_OK, block_index: blk_ff};
            end else begin
               last_in    = link_rd[lba_pkg::BLK_W-1:0];
               link_re    = 1'b1;
               link_raddr = link_rd[lba_pkg::BLK_W-1:0];
            end
         end
         lba_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // File table storage.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         file_mem[file_ff] <= tab_wdata;
      end
      if (tab_re) begin
         tab_rd_ff  <= file_mem[req_word.file_index];
         tab_vld_ff <= file_vld_ff[req_word.file_index];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lba_pkg::ST_IDLE;
         max_ff       <= lba_pkg::MAX_BLOCKS_RESET;
         free_ff      <= '0;
         file_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (format_now) begin
            file_vld_ff <= '0;
         end else if (tab_we) begin
            file_vld_ff[file_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      file_ff  <= file_in;
      blk_ff   <= blk_in;
      last_ff  <= last_in;
      entry_ff <= entry_in;
      res_ff   <= res_in;
      if (rsp_load) begin
         rsp_word_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The free pointer never runs past the end mark.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= lba_pkg::LINK_END)
      else $error("free pointer beyond end of pool");

   // The free pointer only advances by one block or returns to zero on format.
   a_free_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (free_ff != $past(free_ff))) |->
         ((free_ff == $past(free_ff) + 1'b1) || (free_ff == '0)))
      else $error("free pointer moved by more than one block");

   // A file chain never leads into the block being handed out.
   a_walk_no_loop: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lba_pkg::ST_WALK) && !link_end) |->
         (link_rd[lba_pkg::BLK_W-1:0] != blk_ff))
      else $error("chain walk reached the newly allocated block");

   // A response is only loaded once the sequencer has finished.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == lba_pkg::ST_DONE))
      else $error("response raised outside the finishing state");

endmodule

>>> src/lba_link_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module lba_link_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/linked_block_allocator_unit_tb.sv
// Self-checking testbench for linked_block_allocator_unit: directed, exhaustion and random cases.
module linked_block_allocator_unit_tb;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int PHASE_WORDS  = 40;
   localparam int TAIL_CYCLES  = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 4;

   // Every input of the block starts at a known value.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   lba_pkg::req_word_type req_word    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   lba_pkg::rsp_word_type rsp_word;
   logic                  csr_wr_en   = 1'b0;
   logic [3:0]            csr_wr_data = '0;

   // Our own copy of the allocator state: link RAM, free-list head, file table
   // and the block limit register.
   logic [lba_pkg::LINK_W-1:0] link_next   [lba_pkg::NUM_BLOCKS];
   logic [lba_pkg::LINK_W-1:0] free_first;
   logic [lba_pkg::LINK_W-1:0] chain_first [lba_pkg::NUM_FILES];
   logic [lba_pkg::CNT_W-1:0]  blocks_held [lba_pkg::NUM_FILES];
   logic [lba_pkg::CNT_W-1:0]  block_limit;

   // Response words predicted for accepted requests, oldest first.
   lba_pkg::rsp_word_type pending_rsp[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   linked_block_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Format and reset both chain every block into the free list in index
   // order, with the last block pointing at the end mark, and empty every file.
   function automatic void relink_pool();
      for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++) begin
         link_next[i] = lba_pkg::LINK_W'(i + 1);
      end
      free_first = '0;
      for (int f = 0; f < lba_pkg::NUM_FILES; f++) begin
         chain_first[f] = lba_pkg::LINK_END;
         blocks_held[f] = '0;
      end
   endfunction

   // Works out the response word for one request and updates our state.
   function automatic lba_pkg::rsp_word_type alloc_response(lba_pkg::req_word_type w);
      lba_pkg::rsp_word_type      r;
      logic [lba_pkg::LINK_W-1:0] blk;
      logic [lba_pkg::LINK_W-1:0] last;
      int                         steps;
      int                         f;
      r.status      = lba_pkg::STATUS_OK;
      r.block_index = '0;
      f = int'(w.file_index);
      if (w.req_type == lba_pkg::REQ_FORMAT) begin
         relink_pool();
         return r;
      end
      // The limit test comes before the pool test, so a full file is refused
      // with the limit status even when no block is free.
      if (f >= lba_pkg::NUM_FILES || blocks_held[f] >= block_limit) begin
         r.status = lba_pkg::STATUS_LIMIT;
         return r;
      end
      if (free_first >= lba_pkg::LINK_END) begin
         r.status = lba_pkg::STATUS_NO_FREE;
         return r;
      end
      // Pop the free-list head and terminate it.
      blk        = free_first;
      free_first = link_next[blk[lba_pkg::BLK_W-1:0]];
      if (free_first > lba_pkg::LINK_END) free_first = lba_pkg::LINK_END;
      link_next[blk[lba_pkg::BLK_W-1:0]] = lba_pkg::LINK_END;
      // Append it at the tail of the file's chain, found by walking links.
      if (chain_first[f] >= lba_pkg::LINK_END) begin
         chain_first[f] = blk;
      end else begin
         last  = chain_first[f];
         steps = 0;
         while (link_next[last[lba_pkg::BLK_W-1:0]] < lba_pkg::LINK_END &&
                steps < lba_pkg::NUM_BLOCKS) begin
            last = link_next[last[lba_pkg::BLK_W-1:0]];
            steps++;
         end
         link_next[last[lba_pkg::BLK_W-1:0]] = blk;
      end
      blocks_held[f] = blocks_held[f] + 1'b1;
      r.block_index  = blk[lba_pkg::BLK_W-1:0];
      return r;
   endfunction

   // Offers one request word, idling first at the current rate, and records
   // the prediction at the edge where the block takes the word. Valid stays
   // high after acceptance so that back-to-back words need no extra edge.
   task automatic send_request(input logic rtype, input logic [lba_pkg::FILE_W-1:0] file);
      lba_pkg::req_word_type w;
      w.req_type   = rtype;
      w.file_index = file;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(alloc_response(w));
   endtask

   // Lowers valid and waits until every predicted response has come back.
   // At least one edge passes, so valid is never lowered and raised in one step.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // The limit register is only written while the block has nothing in flight.
   task automatic write_limit(input logic [3:0] value);
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      block_limit = value;
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: mostly allocations to a handful of busy files, so that
   // chains grow long and limits are hit, with some spread over all files and
   // an occasional format to start the pool over.
   task automatic run_random_words(input int count);
      logic [lba_pkg::FILE_W-1:0] busy_files [8];
      int                         pick;
      for (int i = 0; i < 8; i++) begin
         busy_files[i] = lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1));
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 2)
            send_request(lba_pkg::REQ_FORMAT,
                         lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1)));
         else if (pick < 85)
            send_request(lba_pkg::REQ_ALLOC, busy_files[$urandom_range(7)]);
         else
            send_request(lba_pkg::REQ_ALLOC,
                         lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1)));
      end
   endtask

   // Format result, filling one file to its limit, the extreme file slots,
   // a limit lowered below a file's count, a limit of zero and the top limit.
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_request(lba_pkg::REQ_FORMAT, '0);
      repeat (11) send_request(lba_pkg::REQ_ALLOC, 7'd0);
      send_request(lba_pkg::REQ_ALLOC, 7'd127);
      send_request(lba_pkg::REQ_ALLOC, 7'd85);
      send_request(lba_pkg::REQ_ALLOC, 7'd42);
      send_request(lba_pkg::REQ_ALLOC, 7'd0);
      write_limit(4'd3);
      send_request(lba_pkg::REQ_ALLOC, 7'd0);
      send_request(lba_pkg::REQ_ALLOC, 7'd127);
      write_limit(4'd0);
      send_request(lba_pkg::REQ_ALLOC, 7'd99);
      write_limit(4'd15);
      send_request(lba_pkg::REQ_ALLOC, 7'd0);
      send_request(lba_pkg::REQ_FORMAT, 7'd127);
   endtask

   // Full-rate traffic on both sides; halfway through, the sender pauses until
   // every response has arrived.
   task automatic test_no_idling();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_limit(4'd15);
      run_random_words(PHASE_WORDS / 2);
      wait_for_responses();
      run_random_words(PHASE_WORDS / 2);
   endtask

   // A sparse sender against the smallest nonzero limit.
   task automatic test_sender_idle();
      send_idle_pct = 80;
      stall_pct     = 0;
      write_limit(4'd1);
      run_random_words(PHASE_WORDS);
   endtask

   // A receiver that stalls most cycles, opening with a long hold-off while
   // the sender keeps offering words, so the block backs up into its input.
   task automatic test_receiver_stall();
      send_idle_pct = 0;
      stall_pct     = 80;
      write_limit(4'($urandom_range(2, 14)));
      hold_left = HOLD_CYCLES;
      run_random_words(PHASE_WORDS);
   endtask

   // Allocates across all files at the top limit until the free list is
   // empty, then keeps asking so that both refusals show up, and formats.
   task automatic test_pool_exhaustion();
      send_idle_pct = 36;
      stall_pct     = 36;
      write_limit(4'd15);
      send_request(lba_pkg::REQ_FORMAT,
                   lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1)));
      while (free_first != lba_pkg::LINK_END)
         send_request(lba_pkg::REQ_ALLOC,
                      lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1)));
      repeat (24) send_request(lba_pkg::REQ_ALLOC,
                               lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1)));
      send_request(lba_pkg::REQ_FORMAT,
                   lba_pkg::FILE_W'($urandom_range(lba_pkg::NUM_FILES - 1)));
   endtask

   // Receiver: either sits out a counted hold-off or stalls at the phase rate.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Checker: every accepted response word is compared with the oldest prediction.
   always @(posedge clock) begin : check_responses
      lba_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response word %h arrived with nothing pending", rsp_word);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.block_index !== want.block_index) begin
               $error("block_index: expected %0d, got %0d",
                      want.block_index, rsp_word.block_index);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linked_block_allocator_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      block_limit = lba_pkg::MAX_BLOCKS_RESET;
      relink_pool();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_pool_exhaustion();

      // Let the last responses drain, then give the block time to show
      // anything unexpected before the verdict.
      wait_for_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("linked_block_allocator_unit_tb: clean");
      end else begin
         $display("linked_block_allocator_unit_tb: errors");
      end
      $finish;
   end

endmodule
